[hw/rtl/diamond_tile_record_decoder_core_defines.svh]
// assertion macros for the diamond tile record decoder
// clocked on i_clk, disabled while i_rst_n is low; no other dependencies
`ifndef DIAMOND_TILE_RECORD_DECODER_CORE_DEFINES_SVH
`define DIAMOND_TILE_RECORD_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define DTRD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define DTRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DTRD_ASSERT_SAME(lbl, ante, cons)
`define DTRD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/dtrd_pkg.sv]
// shared types, constants and the diamond row width function for the decoder
// used by dtrd_decode, dtrd_out_queue and the top level
package dtrd_pkg;

    localparam logic [8:0] DENSE_VALUES = 9'd288;
    localparam logic [9:0] SKIP_MAX     = 10'd1023;
    localparam logic [5:0] DIAMOND_MID  = 6'd24;
    localparam logic [8:0] TILE_ROWS    = 9'd24;
    localparam logic [10:0] TILE_COLS   = 11'd48;

    typedef struct packed {
        logic        clear_tile;
        logic [4:0]  pixel_row;
        logic [5:0]  pixel_column;
        logic [15:0] pixel_value;
        logic        last;
    } t_result;

    // results produced by one byte
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // half-row width of the diamond: 2,4..24 then 22..0
    function automatic logic [4:0] diamond_width(input logic [4:0] r);
        logic [5:0] w;
        if (r <= 5'd11) begin
            w = 6'(({1'b0, r} + 6'd1) << 1);
        end else if (r >= 5'd23) begin
            w = 6'd0;
        end else begin
            w = 6'd46 - {r, 1'b0};
        end
        return w[4:0];
    endfunction

endpackage

[hw/rtl/dtrd_decode.sv]
// record parser: holds the decode state and turns one byte into up to two results
// depends on dtrd_pkg
module dtrd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data_byte,
    input  logic              i_tile_start,
    output dtrd_pkg::t_push   o_push
);
    import dtrd_pkg::*;

    typedef enum logic [3:0] {
        PH_WAIT, PH_DLO, PH_DHI, PH_HX, PH_HY, PH_HW, PH_HH,
        PH_RSEG, PH_SSKIP, PH_SWID, PH_PLO, PH_PHI
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_sparse, n_sparse;
    logic [7:0]  r_origin_x, n_origin_x;
    logic [7:0]  r_origin_y, n_origin_y;
    logic [7:0]  r_rows_total, n_rows_total;
    logic [7:0]  r_row_cnt, n_row_cnt;
    logic [7:0]  r_seg_left, n_seg_left;
    logic [9:0]  r_skip, n_skip;
    logic [7:0]  r_pix_left, n_pix_left;
    logic [7:0]  r_low, n_low;
    logic [4:0]  r_drow, n_drow;
    logic [4:0]  r_dcol, n_dcol;
    logic [8:0]  r_vals_left, n_vals_left;

    logic [4:0]  width;
    logic [15:0] value;
    logic [10:0] xx;
    logic [8:0]  yy;
    logic [10:0] skip_sum;
    logic [7:0]  row_inc;
    logic [7:0]  seg_dec;
    logic [7:0]  pix_dec;
    t_push       push;

    assign width    = diamond_width(r_drow);
    assign value    = {i_data_byte, r_low};
    assign xx       = {3'b000, r_origin_x} + {1'b0, r_skip};
    assign yy       = {1'b0, r_origin_y} + {1'b0, r_row_cnt};
    assign skip_sum = {1'b0, r_skip} + {4'b0000, i_data_byte[7:1]};
    assign row_inc  = r_row_cnt + 8'd1;
    assign seg_dec  = r_seg_left - 8'd1;
    assign pix_dec  = r_pix_left - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_sparse     = r_sparse;
        n_origin_x   = r_origin_x;
        n_origin_y   = r_origin_y;
        n_rows_total = r_rows_total;
        n_row_cnt    = r_row_cnt;
        n_seg_left   = r_seg_left;
        n_skip       = r_skip;
        n_pix_left   = r_pix_left;
        n_low        = r_low;
        n_drow       = r_drow;
        n_dcol       = r_dcol;
        n_vals_left  = r_vals_left;
        push         = '0;

        if (i_tile_start) begin
            n_sparse = i_data_byte[1];
            if (i_data_byte[1]) begin
                n_phase = PH_HX;
            end else begin
                n_phase     = PH_DLO;
                n_vals_left = DENSE_VALUES;
                n_drow      = 5'd0;
                n_dcol      = 5'd0;
            end
            push.count           = 2'd1;
            push.res0.clear_tile = 1'b1;
            push.res0.last       = 1'b1;
        end else begin
            case (r_phase)
                PH_DLO: begin
                    n_low   = i_data_byte;
                    n_phase = PH_DHI;
                end
                PH_DHI: begin
                    push.count             = 2'd2;
                    push.res0.pixel_row    = r_drow;
                    push.res0.pixel_column = DIAMOND_MID - {1'b0, width} + {1'b0, r_dcol};
                    push.res0.pixel_value  = value;
                    push.res1.pixel_row    = r_drow;
                    push.res1.pixel_column = DIAMOND_MID + {1'b0, r_dcol};
                    push.res1.pixel_value  = value;
                    push.res1.last         = 1'b1;
                    n_dcol = r_dcol + 5'd1;
                    if (n_dcol >= width) begin
                        n_dcol = 5'd0;
                        n_drow = r_drow + 5'd1;
                    end
                    n_vals_left = r_vals_left - 9'd1;
                    n_phase     = (n_vals_left == 9'd0) ? PH_WAIT : PH_DLO;
                end
                PH_HX: begin
                    n_origin_x = i_data_byte;
                    n_phase    = PH_HY;
                end
                PH_HY: begin
                    n_origin_y = i_data_byte;
                    n_phase    = PH_HW;
                end
                PH_HW: begin
                    n_phase = PH_HH;
                end
                PH_HH: begin
                    n_rows_total = i_data_byte;
                    n_row_cnt    = 8'd0;
                    n_phase      = (i_data_byte == 8'd0) ? PH_WAIT : PH_RSEG;
                end
                PH_RSEG: begin
                    n_seg_left = i_data_byte;
                    n_skip     = 10'd0;
                    if (i_data_byte == 8'd0) begin
                        n_row_cnt = row_inc;
                        n_phase   = (row_inc == r_rows_total) ? PH_WAIT : PH_RSEG;
                    end else begin
                        n_phase = PH_SSKIP;
                    end
                end
                PH_SSKIP: begin
                    n_skip  = (skip_sum > {1'b0, SKIP_MAX}) ? SKIP_MAX : skip_sum[9:0];
                    n_phase = PH_SWID;
                end
                PH_SWID: begin
                    n_pix_left = i_data_byte;
                    if (i_data_byte != 8'd0) begin
                        n_phase = PH_PLO;
                    end else begin
                        // empty segment closes at once
                        n_seg_left = seg_dec;
                        if (seg_dec != 8'd0) begin
                            n_phase = PH_SSKIP;
                        end else begin
                            n_row_cnt = row_inc;
                            n_phase   = (row_inc == r_rows_total) ? PH_WAIT : PH_RSEG;
                        end
                    end
                end
                PH_PLO: begin
                    n_low   = i_data_byte;
                    n_phase = PH_PHI;
                end
                PH_PHI: begin
                    // off-tile pixels are dropped
                    if (yy < TILE_ROWS && xx < TILE_COLS) begin
                        push.count             = 2'd1;
                        push.res0.pixel_row    = yy[4:0];
                        push.res0.pixel_column = xx[5:0];
                        push.res0.pixel_value  = value;
                        push.res0.last         = 1'b1;
                    end
                    if (r_skip < SKIP_MAX) begin
                        n_skip = r_skip + 10'd1;
                    end
                    n_pix_left = pix_dec;
                    if (pix_dec != 8'd0) begin
                        n_phase = PH_PLO;
                    end else begin
                        n_seg_left = seg_dec;
                        if (seg_dec != 8'd0) begin
                            n_phase = PH_SSKIP;
                        end else begin
                            n_row_cnt = row_inc;
                            n_phase   = (row_inc == r_rows_total) ? PH_WAIT : PH_RSEG;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (!i_step) begin
            push.count = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_sparse     <= 1'b0;
            r_origin_x   <= 8'd0;
            r_origin_y   <= 8'd0;
            r_rows_total <= 8'd0;
            r_row_cnt    <= 8'd0;
            r_seg_left   <= 8'd0;
            r_skip       <= 10'd0;
            r_pix_left   <= 8'd0;
            r_low        <= 8'd0;
            r_drow       <= 5'd0;
            r_dcol       <= 5'd0;
            r_vals_left  <= 9'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_sparse     <= n_sparse;
            r_origin_x   <= n_origin_x;
            r_origin_y   <= n_origin_y;
            r_rows_total <= n_rows_total;
            r_row_cnt    <= n_row_cnt;
            r_seg_left   <= n_seg_left;
            r_skip       <= n_skip;
            r_pix_left   <= n_pix_left;
            r_low        <= n_low;
            r_drow       <= n_drow;
            r_dcol       <= n_dcol;
            r_vals_left  <= n_vals_left;
        end
    end

endmodule

[hw/rtl/dtrd_out_queue.sv]
// four-entry result queue: takes up to two results per cycle, gives one
// depends on dtrd_pkg and the assertion macro header
`include "diamond_tile_record_decoder_core_defines.svh"

module dtrd_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtrd_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output dtrd_pkg::t_result o_head
);
    import dtrd_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_count, n_count;
    logic       pop_ok;

    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd];
    // room for a full two-result request regardless of this cycle's pop
    assign o_room  = (r_count <= 3'd2);
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr + i_push.count;
        n_rd    = r_rd + {1'b0, pop_ok};
        n_count = r_count + {1'b0, i_push.count} - {2'b00, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `DTRD_ASSERT_SAME(a_count_bound, 1'b1, r_count <= 3'd4)
    `DTRD_ASSERT_SAME(a_no_overflow, i_push.count != 2'd0, r_count <= 3'd2)
    `DTRD_ASSERT_SAME(a_pointer_gap, 1'b1, (r_count == 3'd4) || (r_wr - r_rd == r_count[1:0]))
    `DTRD_ASSERT_NEXT(a_pop_only, pop_ok && i_push.count == 2'd0, r_count == $past(r_count) - 3'd1)

endmodule

[hw/rtl/diamond_tile_record_decoder_core.sv]
// diamond tile record decoder: byte stream in, tile pixel writes out
// a byte is held in the input register, decoded, and its results leave from the queue head
// one byte per cycle given room; a dense value gives two results, one leaves per cycle on tready
// the four-entry result queue holds back input only while more than two results wait
// reset (i_rst_n low, synchronous) empties the queue and returns to waiting for a tile start
// depends on dtrd_pkg, dtrd_decode and dtrd_out_queue
module diamond_tile_record_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // tile_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // pixel_row[4:0], pixel_column[10:5], pixel_value[26:11]
    output logic        m_axis_tuser,   // clear_tile
    output logic        m_axis_tlast    // last
);
    import dtrd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       step;
    logic       room;
    t_push      push;
    t_result    head;

    assign step          = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    dtrd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_data_byte  (r_in_byte),
        .i_tile_start (r_in_start),
        .o_push       (push)
    );

    dtrd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .o_head  (head)
    );

    assign m_axis_tdata = {5'b00000, head.pixel_value, head.pixel_column, head.pixel_row};
    assign m_axis_tuser = head.clear_tile;
    assign m_axis_tlast = head.last;

endmodule
